// ===== rtl/core/brd_pkg.sv =====
// ----------------------------------------------------------------------------
// brd_pkg
// Shared types and constants of the ByteRun1 row decoder.
// ----------------------------------------------------------------------------
package brd_pkg;

    localparam int MAX_ROW_BYTES_DEF = 1024;
    localparam int MAX_PLANES        = 9;

    localparam int BYTE_W      = 8;
    localparam int COUNT_W     = 8;
    localparam int ROW_CFG_W   = 11;
    localparam int PLANE_W     = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;

    localparam int RESET_ROW_BYTES = 2;
    localparam logic       RESET_MODE   = 1'b1;
    localparam logic [3:0] RESET_PLANES = 4'd1;

    localparam logic [7:0] NOP_HEADER = 8'd128;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE        = 2'd0,
        CFG_ROW_BYTES   = 2'd1,
        CFG_PLANE_COUNT = 2'd2
    } t_cfg_idx;

    // Control group from the register file to the decode stage
    typedef struct packed {
        logic               mode;     // 1: ByteRun1, 0: pass-through
        logic [PLANE_W-1:0] planes;   // effective plane count, 1..9
        logic               restart;  // one-cycle pulse after a register write
    } t_ctl;

    typedef struct packed {
        logic [BYTE_W-1:0]  value;
        logic [COUNT_W-1:0] repeat_count;
        logic [PLANE_W-1:0] plane_index;
        logic               end_of_row;
        logic               end_of_line;
        logic               error;
    } t_result;

endpackage

// ===== rtl/core/brd_cfg.sv =====
// ----------------------------------------------------------------------------
// brd_cfg
// Configuration registers, effective row length and plane count.
// ----------------------------------------------------------------------------
module brd_cfg
    import brd_pkg::*;
#(
    parameter int MAX_ROW_BYTES = MAX_ROW_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_ctl                  o_ctl,
    output logic [$clog2(MAX_ROW_BYTES+1)-1:0] o_eff_row
);

    localparam int RL_W = $clog2(MAX_ROW_BYTES + 1);

    logic                 r_mode;
    logic [ROW_CFG_W-1:0] r_row_bytes;
    logic [PLANE_W-1:0]   r_planes;
    logic                 r_restart;
    logic [PLANE_W-1:0]   w_eff_planes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= RESET_MODE;
            r_row_bytes <= ROW_CFG_W'(RESET_ROW_BYTES);
            r_planes    <= RESET_PLANES;
            r_restart   <= 1'b0;
        end else begin
            r_restart <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MODE: begin
                        r_mode    <= i_cfg_data[0];
                        r_restart <= 1'b1;
                    end
                    CFG_ROW_BYTES: begin
                        r_row_bytes <= i_cfg_data[ROW_CFG_W-1:0];
                        r_restart   <= 1'b1;
                    end
                    CFG_PLANE_COUNT: begin
                        r_planes  <= i_cfg_data[PLANE_W-1:0];
                        r_restart <= 1'b1;
                    end
                    default: begin
                        r_restart <= 1'b0;
                    end
                endcase
            end
        end
    end

    // Clamp row length to 1..MAX_ROW_BYTES
    always_comb begin
        if (r_row_bytes == '0) begin
            o_eff_row = RL_W'(1);
        end else if (32'(r_row_bytes) > 32'(MAX_ROW_BYTES)) begin
            o_eff_row = RL_W'(MAX_ROW_BYTES);
        end else begin
            o_eff_row = RL_W'(r_row_bytes);
        end
    end

    // Clamp plane count to 1..9
    always_comb begin
        if (r_planes == '0) begin
            w_eff_planes = PLANE_W'(1);
        end else if (32'(r_planes) > 32'(MAX_PLANES)) begin
            w_eff_planes = PLANE_W'(MAX_PLANES);
        end else begin
            w_eff_planes = r_planes;
        end
    end

    assign o_ctl.mode    = r_mode;
    assign o_ctl.planes  = w_eff_planes;
    assign o_ctl.restart = r_restart;

endmodule

// ===== rtl/core/brd_core.sv =====
// ----------------------------------------------------------------------------
// brd_core
// Input register and one-step ByteRun1 decode with row and plane counters.
// ----------------------------------------------------------------------------
module brd_core
    import brd_pkg::*;
#(
    parameter int MAX_ROW_BYTES = MAX_ROW_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_ctl                  i_ctl,
    input  logic [$clog2(MAX_ROW_BYTES+1)-1:0] i_eff_row,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [BYTE_W-1:0]     i_byte_in,
    input  logic                  i_adv,
    output logic                  o_res_valid,
    output t_result               o_res
);

    localparam int RL_W = $clog2(MAX_ROW_BYTES + 1);

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_LITERAL = 2'd1,
        PH_REPEAT  = 2'd2
    } t_phase;

    logic               r_in_valid;
    logic [BYTE_W-1:0]  r_in_byte;
    t_phase             r_phase,     n_phase;
    logic [COUNT_W-1:0] r_pending,   n_pending;
    logic [RL_W-1:0]    r_row_left,  n_row_left;
    logic [PLANE_W-1:0] r_plane,     n_plane;
    logic               r_stopped,   n_stopped;

    logic               w_fire;
    logic               w_emit;
    logic               w_err;
    logic [COUNT_W-1:0] w_emit_n;
    logic [COUNT_W-1:0] w_hdr_len;
    logic [PLANE_W-1:0] w_plane_inc;

    assign w_fire     = r_in_valid && i_adv;
    assign o_in_stall = r_in_valid && !i_adv;

    // Run length of a header byte: h+1 for literals, 257-h for repeats
    assign w_hdr_len = r_in_byte[7] ? COUNT_W'(9'd257 - {1'b0, r_in_byte})
                                    : r_in_byte + COUNT_W'(1);
    assign w_plane_inc = r_plane + PLANE_W'(1);

    always_comb begin
        n_phase    = r_phase;
        n_pending  = r_pending;
        n_row_left = r_row_left;
        n_plane    = r_plane;
        n_stopped  = r_stopped;
        w_emit     = 1'b0;
        w_err      = 1'b0;
        w_emit_n   = COUNT_W'(1);

        if (!r_stopped) begin
            if (!i_ctl.mode) begin
                w_emit = 1'b1;
            end else begin
                case (r_phase)
                    PH_LITERAL: begin
                        w_emit = 1'b1;
                        if (r_pending > COUNT_W'(1)) begin
                            n_pending = r_pending - COUNT_W'(1);
                        end else begin
                            n_pending = '0;
                            n_phase   = PH_HEADER;
                        end
                    end
                    PH_REPEAT: begin
                        w_emit    = 1'b1;
                        w_emit_n  = r_pending;
                        n_pending = '0;
                        n_phase   = PH_HEADER;
                    end
                    PH_HEADER: begin
                        if (r_in_byte != NOP_HEADER) begin
                            if (32'(w_hdr_len) > 32'(r_row_left)) begin
                                w_err     = 1'b1;
                                n_stopped = 1'b1;
                            end else begin
                                n_pending = w_hdr_len;
                                n_phase   = r_in_byte[7] ? PH_REPEAT : PH_LITERAL;
                            end
                        end
                    end
                    default: begin
                        n_phase = PH_HEADER;
                    end
                endcase
            end
        end

        o_res              = '0;
        o_res.plane_index  = r_plane;
        o_res.error        = w_err;
        if (w_emit) begin
            o_res.value        = r_in_byte;
            o_res.repeat_count = w_emit_n;
            // Close the row when this transaction covers what is left of it
            if (32'(w_emit_n) >= 32'(r_row_left)) begin
                n_row_left       = i_eff_row;
                o_res.end_of_row = 1'b1;
                if (w_plane_inc >= i_ctl.planes) begin
                    n_plane           = '0;
                    o_res.end_of_line = 1'b1;
                end else begin
                    n_plane = w_plane_inc;
                end
            end else begin
                n_row_left = RL_W'(32'(r_row_left) - 32'(w_emit_n));
            end
        end
    end

    assign o_res_valid = w_fire && (w_emit || w_err);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= PH_HEADER;
            r_pending  <= '0;
            r_row_left <= RL_W'(RESET_ROW_BYTES);
            r_plane    <= '0;
            r_stopped  <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end
            if (i_ctl.restart) begin
                r_phase    <= PH_HEADER;
                r_pending  <= '0;
                r_row_left <= i_eff_row;
                r_plane    <= '0;
            end else if (w_fire) begin
                r_phase    <= n_phase;
                r_pending  <= n_pending;
                r_row_left <= n_row_left;
                r_plane    <= n_plane;
                r_stopped  <= n_stopped;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_byte_in;
        end
    end

endmodule

// ===== rtl/core/brd_out_reg.sv =====
// ----------------------------------------------------------------------------
// brd_out_reg
// Result register: holds a decoded transaction until the sink takes it.
// ----------------------------------------------------------------------------
module brd_out_reg
    import brd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_data,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_data
);

    logic    r_valid;
    t_result r_data;

    // Free when empty or when the held transaction leaves this cycle
    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== rtl/core/byterun1_row_decoder.sv =====
// The rate is set by the single decode step between the input and result registers:
// a byte is registered, decoded, its result registered. Throughput: one input byte
// per cycle unless stalled; stopped bytes and non-overrun headers give no result.
// Reset (synchronous, active low): ByteRun1 mode, row length 2, one plane,
// header expected, counters cleared, decoding not stopped. No clearing pass.
// ----------------------------------------------------------------------------
// byterun1_row_decoder
// ByteRun1 (PackBits) decoder producing plane-row value/count transactions.
// ----------------------------------------------------------------------------
module byterun1_row_decoder
    import brd_pkg::*;
#(
    parameter int MAX_ROW_BYTES = MAX_ROW_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [BYTE_W-1:0]     i_byte_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [BYTE_W-1:0]     o_value,
    output logic [COUNT_W-1:0]    o_repeat_count,
    output logic [PLANE_W-1:0]    o_plane_index,
    output logic                  o_end_of_row,
    output logic                  o_end_of_line,
    output logic                  o_error
);

    localparam int RL_W = $clog2(MAX_ROW_BYTES + 1);

    t_ctl            w_ctl;
    logic [RL_W-1:0] w_eff_row;
    logic            w_adv;
    logic            w_res_valid;
    t_result         w_res;
    t_result         w_out;

    brd_cfg #(
        .MAX_ROW_BYTES(MAX_ROW_BYTES)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_ctl      (w_ctl),
        .o_eff_row  (w_eff_row)
    );

    brd_core #(
        .MAX_ROW_BYTES(MAX_ROW_BYTES)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_eff_row  (w_eff_row),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_byte_in  (i_byte_in),
        .i_adv      (w_adv),
        .o_res_valid(w_res_valid),
        .o_res      (w_res)
    );

    brd_out_reg u_out (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_load (w_res_valid),
        .i_data (w_res),
        .o_ready(w_adv),
        .o_valid(o_out_valid),
        .i_stall(i_out_stall),
        .o_data (w_out)
    );

    assign o_value        = w_out.value;
    assign o_repeat_count = w_out.repeat_count;
    assign o_plane_index  = w_out.plane_index;
    assign o_end_of_row   = w_out.end_of_row;
    assign o_end_of_line  = w_out.end_of_line;
    assign o_error        = w_out.error;

`ifndef SYNTH
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error |->
            o_repeat_count == '0 && !o_end_of_row && !o_end_of_line)
        else $error("error transaction carries data or row marks");

    a_eol_eor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_end_of_line |-> o_end_of_row)
        else $error("line end without row end");

    a_data_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_error |->
            o_repeat_count != '0 && o_repeat_count <= COUNT_W'(128)
            && o_plane_index < PLANE_W'(MAX_PLANES))
        else $error("data transaction count or plane out of range");
`endif

endmodule

// ===== tb/sv/byterun1_row_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byterun1_row_decoder_tb
// Feeds well-formed ByteRun1 and pass-through byte streams through the decoder
// under several row and plane settings, predicts every run transaction, and
// checks value, count, plane and row/line end flags. It closes with a run
// overrun that must raise the error transaction and stop all later decoding.
// ----------------------------------------------------------------------------
module byterun1_row_decoder_tb;
    import brd_pkg::*;

    localparam int                   CLK_HALF       = 6;
    localparam int                   CYCLE_LIMIT    = 400000;
    localparam int                   TAIL_CYCLES    = 6;
    localparam int                   MAX_RUN        = 128;
    localparam int                   REPEAT_BASE    = 257;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    typedef enum logic [1:0] {
        DEC_HEADER  = 2'd0,
        DEC_LITERAL = 2'd1,
        DEC_REPEAT  = 2'd2
    } t_dec_phase;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    logic [BYTE_W-1:0]     i_byte_in   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [BYTE_W-1:0]     o_value;
    logic [COUNT_W-1:0]    o_repeat_count;
    logic [PLANE_W-1:0]    o_plane_index;
    logic                  o_end_of_row;
    logic                  o_end_of_line;
    logic                  o_error;

    byterun1_row_decoder DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_byte_in      (i_byte_in),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_value        (o_value),
        .o_repeat_count (o_repeat_count),
        .o_plane_index  (o_plane_index),
        .o_end_of_row   (o_end_of_row),
        .o_end_of_line  (o_end_of_line),
        .o_error        (o_error)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Predicted decoder state and settings
    logic                 mode_q;
    logic [ROW_CFG_W-1:0] row_cfg_q;
    logic [PLANE_W-1:0]   planes_cfg_q;
    t_dec_phase           dec_phase;
    logic [COUNT_W-1:0]   run_pending;
    logic [ROW_CFG_W-1:0] row_left;
    logic [PLANE_W-1:0]   plane_ctr;
    logic                 halted;

    t_result           expected_runs[$];
    logic [BYTE_W-1:0] stream_q[$];
    logic              byte_taken = 1'b0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int fail_count     = 0;
    int cycle_count    = 0;
    int bytes_in       = 0;
    int runs_checked   = 0;
    int cfg_writes     = 0;
    int error_seen     = 0;

    // Generator-side view of the row position, used to keep runs well-formed
    logic                 gen_mode;
    logic [ROW_CFG_W-1:0] gen_row;
    int                   gen_left;

    function automatic logic [ROW_CFG_W-1:0] eff_row(input logic [ROW_CFG_W-1:0] rb);
        if (rb == '0) begin
            return ROW_CFG_W'(1);
        end
        if (int'(rb) > MAX_ROW_BYTES_DEF) begin
            return ROW_CFG_W'(MAX_ROW_BYTES_DEF);
        end
        return rb;
    endfunction

    function automatic logic [PLANE_W-1:0] eff_planes(input logic [PLANE_W-1:0] pc);
        if (pc == '0) begin
            return PLANE_W'(1);
        end
        if (int'(pc) > MAX_PLANES) begin
            return PLANE_W'(MAX_PLANES);
        end
        return pc;
    endfunction

    task automatic restart_row();
        dec_phase   = DEC_HEADER;
        run_pending = '0;
        row_left    = eff_row(row_cfg_q);
        plane_ctr   = '0;
    endtask

    task automatic reset_decoder();
        mode_q       = RESET_MODE;
        row_cfg_q    = ROW_CFG_W'(RESET_ROW_BYTES);
        planes_cfg_q = RESET_PLANES;
        halted       = 1'b0;
        restart_row();
    endtask

    task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_MODE:        mode_q       = data[0];
            CFG_ROW_BYTES:   row_cfg_q    = data[ROW_CFG_W-1:0];
            CFG_PLANE_COUNT: planes_cfg_q = data[PLANE_W-1:0];
            default:         return;
        endcase
        restart_row();
    endtask

    // Queue one data transaction covering n bytes and advance row/plane counters
    task automatic emit_run(input logic [BYTE_W-1:0] val, input int n);
        t_result r;
        r              = '0;
        r.value        = val;
        r.repeat_count = n[COUNT_W-1:0];
        r.plane_index  = plane_ctr;
        if (n >= int'(row_left)) begin
            row_left     = eff_row(row_cfg_q);
            r.end_of_row = 1'b1;
            plane_ctr    = plane_ctr + 1'b1;
            if (plane_ctr >= eff_planes(planes_cfg_q)) begin
                plane_ctr     = '0;
                r.end_of_line = 1'b1;
            end
        end else begin
            row_left = row_left - n[ROW_CFG_W-1:0];
        end
        expected_runs.push_back(r);
    endtask

    task automatic decode_byte(input logic [BYTE_W-1:0] b);
        t_result err;
        int      n;
        if (halted) begin
            return;
        end
        if (!mode_q) begin
            emit_run(b, 1);
            return;
        end
        case (dec_phase)
            DEC_LITERAL: begin
                emit_run(b, 1);
                if (run_pending != '0) begin
                    run_pending = run_pending - 1'b1;
                end
                if (run_pending == '0) begin
                    dec_phase = DEC_HEADER;
                end
                return;
            end
            DEC_REPEAT: begin
                emit_run(b, int'(run_pending));
                run_pending = '0;
                dec_phase   = DEC_HEADER;
                return;
            end
            default: ;
        endcase
        if (b == NOP_HEADER) begin
            return;
        end
        n = (b < NOP_HEADER) ? int'(b) + 1 : REPEAT_BASE - int'(b);
        if (n > int'(row_left)) begin
            err             = '0;
            err.plane_index = plane_ctr;
            err.error       = 1'b1;
            expected_runs.push_back(err);
            halted = 1'b1;
            return;
        end
        run_pending = n[COUNT_W-1:0];
        dec_phase   = (b < NOP_HEADER) ? DEC_LITERAL : DEC_REPEAT;
    endtask

    function automatic int check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            return 1;
        end
        return 0;
    endfunction

    // Driver: present the next byte at the falling edge, hold it while stalled
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || byte_taken) begin
            if (stream_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_byte_in  <= stream_q.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Monitor: track writes and accepted bytes, then check each result transaction
    always @(posedge i_clk) begin
        t_result e;
        int      bad;
        if (!i_rst_n) begin
            reset_decoder();
            byte_taken <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                apply_reg(i_cfg_index, i_cfg_data);
            end
            if (i_in_valid && !o_in_stall) begin
                decode_byte(i_byte_in);
                bytes_in++;
            end
            byte_taken <= i_in_valid && !o_in_stall;
            if (o_out_valid && !i_out_stall) begin
                if (expected_runs.size() == 0) begin
                    $error("unexpected result: value %0d count %0d error %0d",
                           o_value, o_repeat_count, o_error);
                    fail_count++;
                end else begin
                    e   = expected_runs.pop_front();
                    bad = check_field("value", int'(e.value), int'(o_value))
                        + check_field("repeat_count", int'(e.repeat_count),
                                      int'(o_repeat_count))
                        + check_field("plane_index", int'(e.plane_index),
                                      int'(o_plane_index))
                        + check_field("end_of_row", int'(e.end_of_row),
                                      int'(o_end_of_row))
                        + check_field("end_of_line", int'(e.end_of_line),
                                      int'(o_end_of_line))
                        + check_field("error", int'(e.error), int'(o_error));
                    if (bad != 0) begin
                        fail_count++;
                    end
                    if (e.error) begin
                        error_seen++;
                    end
                    runs_checked++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("byterun1_row_decoder_tb: FAIL");
            $finish;
        end
    end

    task automatic set_idling(input int sel);
        case (sel)
            0:       begin send_idle_pct = 14; recv_stall_pct = 87; end
            1:       begin send_idle_pct = 87; recv_stall_pct = 14; end
            default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    // Hold off until every queued byte is taken and every result has come back
    task automatic drain();
        while (stream_q.size() != 0 || i_in_valid) begin
            @(posedge i_clk);
        end
        while (expected_runs.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_writes++;
        case (idx)
            CFG_MODE:        gen_mode = data[0];
            CFG_ROW_BYTES:   gen_row  = eff_row(data[ROW_CFG_W-1:0]);
            CFG_PLANE_COUNT: ;
            default:         return;
        endcase
        gen_left = int'(gen_row);
    endtask

    task automatic configure(input logic md, input int rb, input int pc);
        logic [CFG_DATA_W-1:0] mode_word;
        mode_word = {10'($urandom_range(1023)), md};
        write_reg(CFG_PLANE_COUNT, CFG_DATA_W'(pc));
        write_reg(CFG_ROW_BYTES, CFG_DATA_W'(rb));
        write_reg(CFG_MODE, mode_word);
    endtask

    // Push one well-formed run (or a no-op header); return the bytes it uses
    function automatic int push_run();
        int k;
        int cap;
        int n;
        int r;
        k   = $urandom_range(99);
        cap = (gen_left < MAX_RUN) ? gen_left : MAX_RUN;
        if (k < 8) begin
            stream_q.push_back(NOP_HEADER);
            return 1;
        end
        r = $urandom_range(9);
        n = (r == 0) ? 1 : (r == 1) ? cap : $urandom_range(cap, 1);
        gen_left -= n;
        if (gen_left == 0) begin
            gen_left = int'(gen_row);
        end
        if (k < 54 || n < 2) begin
            stream_q.push_back(BYTE_W'(n - 1));
            for (int i = 0; i < n; i++) begin
                stream_q.push_back(BYTE_W'($urandom_range(255)));
            end
            return n + 1;
        end
        stream_q.push_back(BYTE_W'(REPEAT_BASE - n));
        stream_q.push_back(BYTE_W'($urandom_range(255)));
        return 2;
    endfunction

    task automatic run_phase(input int items, input int idle_sel, input bit poke_unused);
        int  sent;
        bit  paused;
        sent   = 0;
        paused = 0;
        set_idling(idle_sel);
        while (sent < items) begin
            if (!paused && sent >= items / 2) begin
                paused = 1;
                drain();
                // an unused register index must leave the row position alone
                if (poke_unused) begin
                    write_reg(CFG_UNUSED_IDX, CFG_DATA_W'($urandom_range(2047)));
                end
            end
            if (!gen_mode) begin
                stream_q.push_back(BYTE_W'($urandom_range(255)));
                sent++;
            end else begin
                sent += push_run();
            end
        end
        drain();
    endtask

    initial begin
        gen_mode = RESET_MODE;
        gen_row  = ROW_CFG_W'(RESET_ROW_BYTES);
        gen_left = RESET_ROW_BYTES;
        set_idling(0);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: single literals at both byte extremes, a no-op header, a
        // repeat of two, then a two-byte literal
        stream_q = '{8'h00, 8'h00, 8'h00, 8'hFF, NOP_HEADER, 8'hFF, 8'h80,
                     8'h01, 8'h7F, 8'h81};
        drain();
        // Longest repeats and the longest literal in a wide two-plane row
        configure(1'b1, MAX_ROW_BYTES_DEF, 2);
        stream_q = '{8'h81, 8'h01, 8'h81, 8'hFE, 8'h00, 8'h55, 8'h7F};
        for (int i = 0; i < MAX_RUN; i++) begin
            stream_q.push_back(BYTE_W'($urandom_range(255)));
        end
        drain();

        configure(1'b1, 1, 1);
        run_phase(45, 0, 0);
        configure(1'b1, 0, 0);
        run_phase(45, 0, 0);
        configure(1'b1, 7, 9);
        run_phase(45, 0, 1);
        configure(1'b0, 5, 15);
        run_phase(45, 1, 0);
        configure(1'b1, 2047, 3);
        run_phase(45, 1, 0);
        configure(1'b1, 300, 2);
        run_phase(45, 1, 0);
        configure(1'b1, 16, 4);
        run_phase(45, 2, 0);
        configure(1'b0, MAX_ROW_BYTES_DEF, MAX_PLANES);
        run_phase(45, 2, 0);
        configure(1'b1, 3, MAX_PLANES);
        run_phase(45, 2, 0);

        // Overrun on the second plane: a repeat of four with two bytes left
        set_idling(0);
        configure(1'b1, 4, 3);
        stream_q = '{8'hFD, 8'h3C, 8'h01, 8'hA5, 8'h5A, 8'hFD};
        for (int i = 0; i < 6; i++) begin
            stream_q.push_back(BYTE_W'($urandom_range(255)));
        end
        drain();
        // stays stopped across a register write
        write_reg(CFG_MODE, CFG_DATA_W'(0));
        for (int i = 0; i < 4; i++) begin
            stream_q.push_back(BYTE_W'($urandom_range(255)));
        end
        drain();

        $display("Decoded %0d input bytes into %0d checked transactions over %0d register writes,",
                 bytes_in, runs_checked, cfg_writes);
        $display("covering pass-through and ByteRun1 modes; overrun errors seen: %0d.",
                 error_seen);
        if (fail_count == 0) begin
            $display("byterun1_row_decoder_tb: PASS");
        end else begin
            $display("byterun1_row_decoder_tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== byterun1_row_decoder.f =====
rtl/core/brd_pkg.sv
rtl/core/brd_cfg.sv
rtl/core/brd_core.sv
rtl/core/brd_out_reg.sv
rtl/core/byterun1_row_decoder.sv
tb/sv/byterun1_row_decoder_tb.sv
